// ===== hdl/lmcs_pkg.sv =====
// Package for the LED matrix column scan shifter.
// Holds the shared constants, the result kind codes, the sequencer types and the hex font.
// Used by lmcs_bitgen, lmcs_seq and led_matrix_column_scan_shifter; depends on nothing.
`timescale 1ns / 1ps

package lmcs_pkg;

    // Geometry of one display and of the chain.
    localparam int DIGITS          = 4;
    localparam int DIGIT_W         = 4;
    localparam int GLYPH_COLS      = 5;
    localparam int GLYPH_ROWS      = 7;
    localparam int MAX_DISPLAYS    = 4;
    localparam int COUNT_W         = 3;
    localparam int COL_W           = 3;
    localparam int ROW_W           = 3;
    localparam int DISP_W          = 2;
    localparam int TDATA_IN_W      = DIGITS * DIGIT_W;
    localparam int TDATA_OUT_W     = 8;

    localparam logic [COUNT_W-1:0] DISPLAY_COUNT_RST = 3'd4;
    localparam logic [COL_W-1:0]   COL_LAST          = 3'(GLYPH_COLS - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST          = 3'(GLYPH_ROWS - 1);

    // What one result item drives.
    typedef enum logic [1:0] {
        CHAIN_ROW   = 2'd0,
        CHAIN_COL   = 2'd1,
        CHAIN_LATCH = 2'd2
    } chain_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROW   = 4'b0010,
        S_COL   = 4'b0100,
        S_LATCH = 4'b1000
    } seq_state_t;

    // One step handed from the sequencer to the bit unit.
    typedef struct packed {
        chain_t               chain;
        logic [DIGIT_W-1:0]   digit;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     pos;
        logic [COL_W-1:0]     col;
    } step_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic idle;
        logic latch;
    } seq_status_t;

    // Hex font, one byte per glyph column; only bits 6..0 are shown.
    localparam logic [7:0] FONT_ROM [0:15][0:GLYPH_COLS-1] = '{
        '{8'hC1, 8'hAE, 8'hB6, 8'hBA, 8'hC1},
        '{8'h7F, 8'hBD, 8'h00, 8'hBF, 8'h7F},
        '{8'h1D, 8'h2E, 8'h36, 8'h36, 8'h39},
        '{8'h5D, 8'h3E, 8'h36, 8'h36, 8'h49},
        '{8'h67, 8'h6B, 8'h6D, 8'h00, 8'h6F},
        '{8'h50, 8'h36, 8'h36, 8'h36, 8'h4E},
        '{8'h41, 8'h36, 8'h36, 8'h36, 8'h4D},
        '{8'h7E, 8'h7E, 8'h0E, 8'h76, 8'h78},
        '{8'h49, 8'h36, 8'h36, 8'h36, 8'h49},
        '{8'h59, 8'h36, 8'h36, 8'h36, 8'h41},
        '{8'h01, 8'h76, 8'h76, 8'h76, 8'h01},
        '{8'h00, 8'h36, 8'h36, 8'h36, 8'h49},
        '{8'h41, 8'h3E, 8'h3E, 8'h3E, 8'h5D},
        '{8'h00, 8'hBE, 8'hBE, 8'hBE, 8'h41},
        '{8'h00, 8'h36, 8'h36, 8'h36, 8'h3E},
        '{8'h00, 8'h76, 8'h76, 8'h76, 8'h7E}
    };

endpackage

// ===== hdl/lmcs_bitgen.sv =====
// Shared bit unit: turns one sequencer step into the serial data bit.
// Does the font lookup and row select for row shifts and the column compare for column shifts.
// Depends on lmcs_pkg.
`timescale 1ns / 1ps

module lmcs_bitgen
(
    input  lmcs_pkg::step_t step,
    output logic            data_bit
);

    logic [7:0] glyph;

    // Font column of the current digit.
    assign glyph = lmcs_pkg::FONT_ROM[step.digit][step.col];

    // Row shifts send the top row first; a column bit is set when pos + col + 1 equals five.
    always_comb
    begin
        case (step.chain)
            lmcs_pkg::CHAIN_ROW:
            begin
                data_bit = glyph[lmcs_pkg::ROW_LAST - step.row];
            end
            lmcs_pkg::CHAIN_COL:
            begin
                data_bit = (step.pos == (lmcs_pkg::COL_LAST - step.col));
            end
            default:
            begin
                data_bit = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/lmcs_seq.sv =====
// Scan sequencer: walks the row bits, the column bits and the latch of one scan tick.
// Holds the digits of the item in progress and the glyph column counter.
// Depends on lmcs_pkg.
`timescale 1ns / 1ps

module lmcs_seq
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [lmcs_pkg::TDATA_IN_W-1:0]      digits_in,
    input  logic [lmcs_pkg::COUNT_W-1:0]         n_eff,
    input  logic                                 advance,
    output lmcs_pkg::step_t                      step,
    output lmcs_pkg::seq_status_t                status
);

    lmcs_pkg::seq_state_t                state_reg, state_next;
    logic [lmcs_pkg::TDATA_IN_W-1:0]     digits_reg, digits_next;
    logic [lmcs_pkg::DISP_W-1:0]         disp_reg, disp_next;
    logic [lmcs_pkg::ROW_W-1:0]          row_reg, row_next;
    logic [lmcs_pkg::COL_W-1:0]          pos_reg, pos_next;
    logic [lmcs_pkg::COL_W-1:0]          scan_col_reg, scan_col_next;
    logic                                last_disp;

    assign last_disp = ({1'b0, disp_reg} == (n_eff - 3'd1));

    // Next-state logic: one step per cycle in which the output slot is free.
    always_comb
    begin
        state_next    = state_reg;
        digits_next   = digits_reg;
        disp_next     = disp_reg;
        row_next      = row_reg;
        pos_next      = pos_reg;
        scan_col_next = scan_col_reg;
        case (state_reg)
            lmcs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    digits_next = digits_in;
                    disp_next   = '0;
                    row_next    = '0;
                    pos_next    = '0;
                    state_next  = (n_eff == '0) ? lmcs_pkg::S_LATCH : lmcs_pkg::S_ROW;
                end
            end
            lmcs_pkg::S_ROW:
            begin
                if (advance)
                begin
                    if (row_reg == lmcs_pkg::ROW_LAST)
                    begin
                        row_next = '0;
                        if (last_disp)
                        begin
                            disp_next  = '0;
                            state_next = lmcs_pkg::S_COL;
                        end
                        else
                        begin
                            disp_next = disp_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        row_next = row_reg + 3'd1;
                    end
                end
            end
            lmcs_pkg::S_COL:
            begin
                if (advance)
                begin
                    if (pos_reg == lmcs_pkg::COL_LAST)
                    begin
                        pos_next = '0;
                        if (last_disp)
                        begin
                            disp_next  = '0;
                            state_next = lmcs_pkg::S_LATCH;
                        end
                        else
                        begin
                            disp_next = disp_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
            end
            lmcs_pkg::S_LATCH:
            begin
                if (advance)
                begin
                    scan_col_next = (scan_col_reg == lmcs_pkg::COL_LAST) ? '0
                                                                         : scan_col_reg + 3'd1;
                    state_next    = lmcs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lmcs_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lmcs_pkg::S_IDLE;
            disp_reg     <= '0;
            row_reg      <= '0;
            pos_reg      <= '0;
            scan_col_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            disp_reg     <= disp_next;
            row_reg      <= row_next;
            pos_reg      <= pos_next;
            scan_col_reg <= scan_col_next;
        end
    end

    // Digit payload of the item in progress.
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
    end

    // Step handed to the bit unit.
    always_comb
    begin
        case (state_reg)
            lmcs_pkg::S_ROW:
            begin
                step.chain = lmcs_pkg::CHAIN_ROW;
            end
            lmcs_pkg::S_COL:
            begin
                step.chain = lmcs_pkg::CHAIN_COL;
            end
            default:
            begin
                step.chain = lmcs_pkg::CHAIN_LATCH;
            end
        endcase
        step.digit = digits_reg[{disp_reg, 2'b00} +: lmcs_pkg::DIGIT_W];
        step.row   = row_reg;
        step.pos   = pos_reg;
        step.col   = scan_col_reg;
    end

    assign status.idle  = (state_reg == lmcs_pkg::S_IDLE);
    assign status.latch = (state_reg == lmcs_pkg::S_LATCH);

endmodule

// ===== hdl/led_matrix_column_scan_shifter.sv =====
// Top level of the LED matrix column scan shifter.
// Depends on lmcs_pkg, lmcs_seq and lmcs_bitgen.
//
// Usage:
// Each item on the slave stream is one scan tick carrying four hex digits. The block shows
// the current glyph column on every enabled display: for each display, digit 0 first, it
// sends 7 row shift items (top row first), then 5 column shift items per display, then one
// latch item with tlast set. The glyph column then advances, wrapping after column 4.
// display_count is written through cfg_we/cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce. Values above MAX_DISPLAYS act as
// MAX_DISPLAYS, and zero gives a tick with only the latch item. The sequencer drives one
// result item per cycle into the output register whenever it is empty or being taken, through
// the shared bit unit; a tick of n displays is 12*n + 1 items (49 for four). s_tready is
// high only while the sequencer is idle, which includes the cycles in which the latch item
// still waits. A stalled master side freezes the sequencer; nothing is dropped.
// Reset sets display_count to 4 and the glyph column to 0, and empties the output register.
`timescale 1ns / 1ps

module led_matrix_column_scan_shifter
#(
    parameter int MAX_DISPLAYS = lmcs_pkg::MAX_DISPLAYS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: display_count.
    input  logic                                cfg_we,
    input  logic [lmcs_pkg::COUNT_W-1:0]        cfg_data,
    // Slave stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lmcs_pkg::TDATA_IN_W-1:0]     s_tdata,   // digit_0, digit_1, digit_2, digit_3
    // Master stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lmcs_pkg::TDATA_OUT_W-1:0]    m_tdata,   // data_bit, then zero fill
    output logic [1:0]                          m_tuser,   // chain
    output logic                                m_tlast    // last
);

    logic [lmcs_pkg::COUNT_W-1:0]   display_count_reg;
    logic [lmcs_pkg::COUNT_W-1:0]   n_eff;
    logic                           advance;
    logic                           load;
    logic                           start;
    logic                           bit_out;
    lmcs_pkg::step_t                step;
    lmcs_pkg::seq_status_t          status;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic                           data_reg;
    lmcs_pkg::chain_t               chain_reg;
    logic                           last_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_count_reg <= lmcs_pkg::DISPLAY_COUNT_RST;
        end
        else if (cfg_we)
        begin
            display_count_reg <= cfg_data;
        end
    end

    // Effective display count, saturated to the chain length.
    assign n_eff = (display_count_reg > lmcs_pkg::COUNT_W'(MAX_DISPLAYS))
                   ? lmcs_pkg::COUNT_W'(MAX_DISPLAYS) : display_count_reg;

    // Handshake glue.
    assign s_tready = status.idle;
    assign start    = s_tvalid && s_tready;
    assign advance  = !m_tvalid_reg || m_tready;
    assign load     = !status.idle && advance;

    lmcs_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .digits_in (s_tdata),
        .n_eff     (n_eff),
        .advance   (advance),
        .step      (step),
        .status    (status)
    );

    lmcs_bitgen u_bitgen
    (
        .step     (step),
        .data_bit (bit_out)
    );

    // Output register valid flag.
    always_comb
    begin
        if (load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg  <= bit_out;
            chain_reg <= step.chain;
            last_reg  <= status.latch;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(lmcs_pkg::TDATA_OUT_W-1){1'b0}}, data_reg};
    assign m_tuser  = chain_reg;
    assign m_tlast  = last_reg;

    // The glyph column never leaves the font range.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        step.col <= lmcs_pkg::COL_LAST)
        else $error("glyph column out of range");

    // A latch step taken into the output register frees the input side next cycle.
    a_latch_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (status.latch && advance) |=> s_tready)
        else $error("block not ready after the latch item");

    // Only the latch item ends a tick, and it carries a zero bit.
    a_last_is_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == lmcs_pkg::CHAIN_LATCH && m_tdata == '0))
        else $error("last set on a shift item");

    // A latch item always ends the tick.
    a_latch_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == lmcs_pkg::CHAIN_LATCH) |-> m_tlast)
        else $error("latch item without last");

    // An accepted item starts its work at once.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_tready)
        else $error("sequencer idle after an accepted item");

endmodule
